// File: src/stbs_pkg.sv
// Shared types and constants for the sorted key/value table with binary search.
// No dependencies; used by sorted_table_binary_search.
`default_nettype none

package stbs_pkg;

    // default number of table entries
    localparam int CAPACITY_DEF = 256;

    // field widths
    localparam int KEY_W = 64;
    localparam int VAL_W = 32;
    localparam int ENT_W = KEY_W + VAL_W;

    // command codes carried on the request tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

// File: src/sorted_table_binary_search.sv
// Sorted key/value table: append-only insert, binary-search lookup over one entry memory.
// Depends on stbs_pkg for widths, command codes and the sequencer state type.
`default_nettype none

// Holds up to CAPACITY entries of a 64-bit key and a 32-bit value in one
// single-port memory with a registered read. Every request yields exactly one
// response. An insert appends at the next free slot (keys must arrive in
// ascending order). It then passes through the result state, which loads the
// response register once the output side is free; only then is the next request
// taken. An insert into a full table is refused with the rejected flag. A lookup
// issues one memory probe per cycle in the search state, then loads the response
// register from the result state in the same way. P, the number of probes, is
// at most clog2(entry count) + 1 (9 for a full table of 256). The single
// read port of the entry memory and its registered read set this pace.
// The response register lets a new request be taken while the previous response
// waits on the output side. There is no clearing pass after reset.
module sorted_table_binary_search #(
    parameter int CAPACITY = stbs_pkg::CAPACITY_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // request channel
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [stbs_pkg::ENT_W-1:0] s_axis_tdata,  // [63:0] key_in, [95:64] value_in
    input  wire logic                       s_axis_tuser,  // [0] cmd
    // response channel
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [stbs_pkg::VAL_W-1:0]      m_axis_tdata,  // [31:0] value_out
    output logic [1:0]                      m_axis_tuser   // [0] found, [1] rejected
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = stbs_pkg::KEY_W;
    localparam int VW = stbs_pkg::VAL_W;
    localparam int EW = stbs_pkg::ENT_W;

    // entry memory: value in the upper bits, key in the lower bits
    logic [EW-1:0] r_mem [CAPACITY];
    logic [EW-1:0] r_rd;

    stbs_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [IW-1:0]    r_probe, n_probe;
    logic [KW-1:0]    r_key, n_key;
    logic             r_res_found, n_res_found;
    logic             r_res_rej, n_res_rej;
    logic [VW-1:0]    r_res_val, n_res_val;

    logic             r_out_valid;
    logic             r_out_found;
    logic             r_out_rej;
    logic [VW-1:0]    r_out_val;

    logic             mem_we;
    logic [IW-1:0]    mem_addr;
    logic             in_req;
    logic             out_load;
    logic [KW-1:0]    rd_key;
    logic [CW-1:0]    lo2, hi2, mid2;

    assign in_req = s_axis_tvalid && s_axis_tready;
    assign rd_key = r_rd[KW-1:0];

    // narrowed bounds after comparing against the probed entry
    always_comb begin
        lo2 = r_lo;
        hi2 = r_hi;
        if (r_key < rd_key) begin
            hi2 = CW'(r_probe);
        end else begin
            lo2 = CW'(r_probe) + CW'(1);
        end
        mid2 = lo2 + ((hi2 - lo2) >> 1);
    end

    // sequencer: next state, memory port and pending response
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_probe       = r_probe;
        n_key         = r_key;
        n_res_found   = r_res_found;
        n_res_rej     = r_res_rej;
        n_res_val     = r_res_val;
        mem_we        = 1'b0;
        mem_addr      = r_probe;
        out_load      = 1'b0;
        s_axis_tready = 1'b0;
        case (r_state)
            stbs_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_req) begin
                    n_res_found = 1'b0;
                    n_res_rej   = 1'b0;
                    n_res_val   = '0;
                    if (s_axis_tuser == stbs_pkg::CMD_INSERT) begin
                        if (r_count < CW'(CAPACITY)) begin
                            mem_we   = 1'b1;
                            mem_addr = r_count[IW-1:0];
                            n_count  = r_count + CW'(1);
                        end else begin
                            n_res_rej = 1'b1;
                        end
                        n_state = stbs_pkg::S_RESULT;
                    end else begin
                        n_key = s_axis_tdata[KW-1:0];
                        if (r_count == '0) begin
                            n_state = stbs_pkg::S_RESULT;
                        end else begin
                            n_lo     = '0;
                            n_hi     = r_count;
                            n_probe  = IW'(r_count >> 1);
                            mem_addr = n_probe;
                            n_state  = stbs_pkg::S_SEARCH;
                        end
                    end
                end
            end
            stbs_pkg::S_SEARCH: begin
                if (r_key == rd_key) begin
                    n_res_found = 1'b1;
                    n_res_val   = r_rd[EW-1:KW];
                    n_state     = stbs_pkg::S_RESULT;
                end else if (lo2 < hi2) begin
                    n_lo     = lo2;
                    n_hi     = hi2;
                    n_probe  = mid2[IW-1:0];
                    mem_addr = n_probe;
                end else begin
                    n_state = stbs_pkg::S_RESULT;
                end
            end
            stbs_pkg::S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = stbs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stbs_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbs_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // search bounds and pending response
    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_probe     <= n_probe;
        r_key       <= n_key;
        r_res_found <= n_res_found;
        r_res_rej   <= n_res_rej;
        r_res_val   <= n_res_val;
    end

    // entry memory, one access per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= {s_axis_tdata[EW-1:KW], s_axis_tdata[KW-1:0]};
        end
        r_rd <= r_mem[mem_addr];
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_found <= r_res_found;
            r_out_rej   <= r_res_rej;
            r_out_val   <= r_res_val;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_val;
    assign m_axis_tuser  = {r_out_rej, r_out_found};

`ifndef SYNTHESIS
    // fill count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // an active search always probes inside its open range
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == stbs_pkg::S_SEARCH |->
            (r_lo < r_hi) && (CW'(r_probe) >= r_lo) && (CW'(r_probe) < r_hi)
            && (r_hi <= r_count))
        else $error("probe outside search range");

    // an insert into a non-full table grows the count by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req && (s_axis_tuser == stbs_pkg::CMD_INSERT) && (r_count < CW'(CAPACITY))
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not advance count");

    // a response never reports both a hit and a refusal, and a miss carries zero
    a_resp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_found && r_out_rej) && (r_out_found || r_out_val == '0))
        else $error("inconsistent response flags");
`endif

endmodule

`default_nettype wire

// File: tb/sorted_table_binary_search_checker.sv
// Response checker for the sorted key/value table: watches both stream channels,
// keeps its own copy of the table and compares every response against it.
// Depends on stbs_pkg for field widths and command codes.
`default_nettype none

module sorted_table_binary_search_checker #(
    parameter int CAPACITY = stbs_pkg::CAPACITY_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // request channel, observed
    input  wire logic                       i_req_valid,
    input  wire logic                       i_req_ready,
    input  wire logic [stbs_pkg::ENT_W-1:0] i_req_data,   // [63:0] key_in, [95:64] value_in
    input  wire logic                       i_req_user,   // [0] cmd
    // response channel, observed
    input  wire logic                       i_rsp_valid,
    input  wire logic                       i_rsp_ready,
    input  wire logic [stbs_pkg::VAL_W-1:0] i_rsp_data,   // [31:0] value_out
    input  wire logic [1:0]                 i_rsp_user,   // [0] found, [1] rejected
    // status toward the testbench top
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_hit_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                       found;
        logic [stbs_pkg::VAL_W-1:0] value;
        logic                       rejected;
    } t_table_resp;

    // shadow copy of the table
    logic [stbs_pkg::KEY_W-1:0] shadow_keys   [CAPACITY];
    logic [stbs_pkg::VAL_W-1:0] shadow_values [CAPACITY];
    int                         shadow_fill = 0;

    // responses still owed by the block, oldest first
    t_table_resp                owed_responses[$];

    // apply one request to the shadow table and work out its response
    function automatic t_table_resp apply_table_request(
        input logic                       cmd,
        input logic [stbs_pkg::KEY_W-1:0] key,
        input logic [stbs_pkg::VAL_W-1:0] value
    );
        t_table_resp resp;
        int          lo;
        int          hi;
        int          probe;
        resp = '0;
        if (cmd == stbs_pkg::CMD_INSERT) begin
            // a full table refuses the insert and stays unchanged
            if (shadow_fill >= CAPACITY) begin
                resp.rejected = 1'b1;
            end else begin
                shadow_keys[shadow_fill]   = key;
                shadow_values[shadow_fill] = value;
                shadow_fill++;
            end
        end else begin
            // binary search over the filled entries, first match met wins
            lo = 0;
            hi = shadow_fill;
            while (lo < hi && !resp.found) begin
                probe = lo + (hi - lo) / 2;
                if (key < shadow_keys[probe]) begin
                    hi = probe;
                end else if (key > shadow_keys[probe]) begin
                    lo = probe + 1;
                end else begin
                    resp.found = 1'b1;
                    resp.value = shadow_values[probe];
                end
            end
        end
        return resp;
    endfunction

    // compare responses first, then record new requests
    always @(posedge i_clk) begin
        t_table_resp want;
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (owed_responses.size() == 0) begin
                    $display("%0t: response with none expected: found %0b value %h rejected %0b",
                             $time, i_rsp_user[0], i_rsp_data, i_rsp_user[1]);
                    o_fail_count++;
                end else begin
                    want = owed_responses.pop_front();
                    if (i_rsp_user[0] !== want.found) begin
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, want.found, i_rsp_user[0]);
                        o_fail_count++;
                    end
                    if (i_rsp_data !== want.value) begin
                        $display("%0t: value_out mismatch: expected %h actual %h",
                                 $time, want.value, i_rsp_data);
                        o_fail_count++;
                    end
                    if (i_rsp_user[1] !== want.rejected) begin
                        $display("%0t: rejected mismatch: expected %0b actual %0b",
                                 $time, want.rejected, i_rsp_user[1]);
                        o_fail_count++;
                    end
                    if (want.found) begin
                        o_hit_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                owed_responses.push_back(apply_table_request(
                    i_req_user,
                    i_req_data[stbs_pkg::KEY_W-1:0],
                    i_req_data[stbs_pkg::ENT_W-1:stbs_pkg::KEY_W]));
            end
        end
        o_pending = owed_responses.size();
    end

endmodule

`default_nettype wire

// File: tb/sorted_table_binary_search_tb.sv
// Testbench top for sorted_table_binary_search: clock, reset, request stimulus,
// response back-pressure and the final verdict; checking lives in the checker module.
// Depends on stbs_pkg, sorted_table_binary_search and sorted_table_binary_search_checker.
`default_nettype none

module sorted_table_binary_search_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = stbs_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1040;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [stbs_pkg::KEY_W-1:0] KEY_MAX = '1;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [stbs_pkg::ENT_W-1:0] s_axis_tdata;   // [63:0] key_in, [95:64] value_in
    logic                       s_axis_tuser;   // [0] cmd
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [stbs_pkg::VAL_W-1:0] m_axis_tdata;   // [31:0] value_out
    logic [1:0]                 m_axis_tuser;   // [0] found, [1] rejected

    int fail_count;
    int pending_count;
    int hit_count;

    // stimulus bookkeeping
    logic [stbs_pkg::KEY_W-1:0] inserted_keys[$];
    logic [stbs_pkg::KEY_W-1:0] last_key;
    int                         entries_sent;
    int                         insert_count;
    int                         refused_count;
    int                         lookup_count;
    int                         burst_left;

    sorted_table_binary_search #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sorted_table_binary_search_checker #(
        .CAPACITY(CAPACITY)
    ) table_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .i_rsp_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_hit_count  (hit_count)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // run limit
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("sorted_table_binary_search regression: fail");
        $finish;
    end

    // response back-pressure: modes of random length, from always ready to mostly stalled
    initial begin
        int mode;
        int span;
        m_axis_tready = 1'b0;
        mode = 0;
        span = 0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 150);
            end
            span--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                2: m_axis_tready <= ($urandom_range(0, 4) == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // present one request at the falling edge and hold it until accepted
    task automatic send_request(
        input logic                       cmd,
        input logic [stbs_pkg::KEY_W-1:0] key,
        input logic [stbs_pkg::VAL_W-1:0] value
    );
        int gap;
        if (burst_left == 0) begin
            // idle gap between bursts
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= cmd;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
        burst_left--;
        if (cmd == stbs_pkg::CMD_INSERT) begin
            insert_count++;
            if (entries_sent >= CAPACITY) begin
                refused_count++;
            end else begin
                inserted_keys.push_back(key);
                entries_sent++;
            end
        end else begin
            lookup_count++;
        end
    endtask

    // next key of the ascending insert sequence, with duplicates and large steps
    function automatic logic [stbs_pkg::KEY_W-1:0] next_ascending_key();
        logic [stbs_pkg::KEY_W-1:0] step;
        logic [stbs_pkg::KEY_W-1:0] next;
        case ($urandom_range(0, 9))
            0: step = '0;
            1: step = 64'd1;
            2, 3, 4: step = 64'($urandom_range(2, 1000));
            default: step = {10'd0, 22'($urandom_range(0, 4194303)), 32'($urandom)};
        endcase
        next = last_key + step;
        return (next < last_key) ? KEY_MAX : next;
    endfunction

    // random value with its extremes now and then
    function automatic logic [stbs_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return 32'($urandom);
        endcase
    endfunction

    // lookup key: stored keys half the time, some neighbors, extremes and random keys
    function automatic logic [stbs_pkg::KEY_W-1:0] pick_lookup_key();
        int                         sel;
        logic [stbs_pkg::KEY_W-1:0] base;
        sel  = $urandom_range(0, 99);
        base = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        if (sel < 50) begin
            return base;
        end else if (sel < 65) begin
            return ($urandom_range(0, 1) == 1) ? base + 64'd1 : base - 64'd1;
        end else if (sel < 72) begin
            return ($urandom_range(0, 1) == 1) ? KEY_MAX : '0;
        end else begin
            return {32'($urandom), 32'($urandom)};
        end
    endfunction

    // stimulus and verdict
    initial begin
        logic [stbs_pkg::KEY_W-1:0] key;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = stbs_pkg::CMD_INSERT;
        last_key      = '0;
        entries_sent  = 0;
        insert_count  = 0;
        refused_count = 0;
        lookup_count  = 0;
        burst_left    = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, key and value extremes, duplicates, near misses
        send_request(stbs_pkg::CMD_LOOKUP, '0, '1);
        send_request(stbs_pkg::CMD_LOOKUP, KEY_MAX, '0);
        send_request(stbs_pkg::CMD_INSERT, '0, '1);
        send_request(stbs_pkg::CMD_LOOKUP, '0, '0);
        send_request(stbs_pkg::CMD_LOOKUP, 64'd1, '0);
        send_request(stbs_pkg::CMD_LOOKUP, KEY_MAX, '0);
        send_request(stbs_pkg::CMD_INSERT, '0, '0);
        send_request(stbs_pkg::CMD_LOOKUP, '0, '1);
        send_request(stbs_pkg::CMD_INSERT, 64'h100, 32'hA5A5_A5A5);
        send_request(stbs_pkg::CMD_INSERT, 64'h200, 32'h5A5A_5A5A);
        send_request(stbs_pkg::CMD_LOOKUP, 64'h100, '0);
        send_request(stbs_pkg::CMD_LOOKUP, 64'h200, '0);
        send_request(stbs_pkg::CMD_LOOKUP, 64'h1FF, '0);
        send_request(stbs_pkg::CMD_LOOKUP, 64'h201, '0);
        send_request(stbs_pkg::CMD_LOOKUP, 64'h0FF, '0);
        last_key = 64'h200;

        // random: mostly ascending inserts until full, then refused inserts, lookups throughout
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 30) begin
                if (entries_sent >= CAPACITY) begin
                    key = {32'($urandom), 32'($urandom)};
                end else if (entries_sent == CAPACITY - 1) begin
                    key = KEY_MAX;
                end else if ($urandom_range(0, 99) < 3) begin
                    // out-of-order key
                    key = {32'($urandom), 32'($urandom)};
                end else begin
                    key = next_ascending_key();
                    last_key = key;
                end
                send_request(stbs_pkg::CMD_INSERT, key, pick_value());
            end else begin
                send_request(stbs_pkg::CMD_LOOKUP, pick_lookup_key(), 32'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding responses
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d requests: %0d inserts, %0d of them refused on a full table",
                 insert_count + lookup_count, insert_count, refused_count);
        $display("and %0d lookups, %0d of them hits", lookup_count, hit_count);
        if (fail_count == 0) begin
            $display("sorted_table_binary_search regression: pass");
        end else begin
            $display("sorted_table_binary_search regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
src/stbs_pkg.sv
src/sorted_table_binary_search.sv
tb/sorted_table_binary_search_checker.sv
tb/sorted_table_binary_search_tb.sv
